/* src/bcbg_pkg.sv */
// Package for the backoff circuit breaker guard.
// Field widths, request, reason and breaker codes, register indexes and the
// control structs shared by the controller, datapath and register file.
package bcbg_pkg;

   localparam int NOW_W    = 47;
   localparam int TIME_W   = 48;
   localparam int SLOT_W   = 6;
   localparam int CFG_W    = 32;
   localparam int MAXREL_W = 5;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] REQ_DECIDE  = 2'd0;
   localparam logic [1:0] REQ_RECORD  = 2'd1;
   localparam logic [1:0] REQ_HEALTHY = 2'd2;

   localparam logic [1:0] MODE_CLOSED = 2'd0;
   localparam logic [1:0] MODE_OPEN   = 2'd1;
   localparam logic [1:0] MODE_HALF   = 2'd2;

   localparam logic [1:0] REASON_NONE    = 2'd0;
   localparam logic [1:0] REASON_BACKOFF = 2'd1;
   localparam logic [1:0] REASON_OPEN    = 2'd2;
   localparam logic [1:0] REASON_HALF    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_BASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_CAP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RELAUNCH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN     = 3'd4;

   localparam logic [CFG_W-1:0]    RST_BACKOFF_BASE = 32'd1000;
   localparam logic [CFG_W-1:0]    RST_BACKOFF_CAP  = 32'd300000;
   localparam logic [CFG_W-1:0]    RST_WINDOW       = 32'd600000;
   localparam logic [MAXREL_W-1:0] RST_MAX_RELAUNCH = 5'd3;
   localparam logic [CFG_W-1:0]    RST_COOLDOWN     = 32'd300000;

   typedef struct packed {
      logic [CFG_W-1:0]    base_ms;
      logic [CFG_W-1:0]    cap_ms;
      logic [CFG_W-1:0]    window_ms;
      logic [MAXREL_W-1:0] max_relaunches;
      logic [CFG_W-1:0]    cooldown_ms;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic slot_rd;
      logic calc;
      logic arm;
      logic half_set;
      logic healthy_clr;
      logic clr_start;
      logic clr_step;
      logic win_start;
      logic win_rd;
      logic win_chk;
      logic win_ins;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       is_relaunch;
      logic [1:0] mode;
      logic       clr_last;
      logic       win_last;
   } status_type;

endpackage

/* src/bcbg_ifs.sv */
// Channel interfaces for the backoff circuit breaker guard.
// Request and response beats with valid/ready; slot and time widths from bcbg_pkg.
interface bcbg_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [bcbg_pkg::SLOT_W-1:0] sig_slot;
   logic                        is_relaunch;
   logic [bcbg_pkg::NOW_W-1:0]  now_ms;

   modport source (output valid, output req_type, output sig_slot,
                   output is_relaunch, output now_ms, input ready);
   modport sink   (input valid, input req_type, input sig_slot,
                   input is_relaunch, input now_ms, output ready);
endinterface

interface bcbg_rsp_if;
   logic       valid;
   logic       ready;
   logic       allowed;
   logic [1:0] deny_reason;
   logic [1:0] breaker_now;

   modport source (output valid, output allowed, output deny_reason,
                   output breaker_now, input ready);
   modport sink   (input valid, input allowed, input deny_reason,
                   input breaker_now, output ready);
endinterface

/* src/bcbg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcbg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/bcbg_csr.sv */
// Configuration register file for the backoff circuit breaker guard.
// Uses bcbg_pkg for register indexes, reset values and cfg_type.
module bcbg_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bcbg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcbg_pkg::CFG_W-1:0]     csr_wdata,
   output bcbg_pkg::cfg_type              cfg
);
   bcbg_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_ms        <= bcbg_pkg::RST_BACKOFF_BASE;
         cfg_ff.cap_ms         <= bcbg_pkg::RST_BACKOFF_CAP;
         cfg_ff.window_ms      <= bcbg_pkg::RST_WINDOW;
         cfg_ff.max_relaunches <= bcbg_pkg::RST_MAX_RELAUNCH;
         cfg_ff.cooldown_ms    <= bcbg_pkg::RST_COOLDOWN;
      end else if (csr_we) begin
         case (csr_index)
            bcbg_pkg::CSR_BACKOFF_BASE: cfg_ff.base_ms     <= csr_wdata;
            bcbg_pkg::CSR_BACKOFF_CAP:  cfg_ff.cap_ms      <= csr_wdata;
            bcbg_pkg::CSR_WINDOW:       cfg_ff.window_ms   <= csr_wdata;
            bcbg_pkg::CSR_MAX_RELAUNCH:
               cfg_ff.max_relaunches <= csr_wdata[bcbg_pkg::MAXREL_W-1:0];
            bcbg_pkg::CSR_COOLDOWN:     cfg_ff.cooldown_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

/* src/bcbg_ctrl.sv */
// Sequencing controller for the backoff circuit breaker guard.
// Issues cmd_type to the datapath from status_type; owns the response valid.
module bcbg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bcbg_pkg::status_type status,
   output bcbg_pkg::cmd_type    cmd
);
   typedef enum logic [3:0] {
      ST_CLR_RST,
      ST_IDLE,
      ST_SLOT_RD,
      ST_CALC,
      ST_ARM,
      ST_WIN_RD,
      ST_WIN_CHK,
      ST_WIN_INS,
      ST_CLR_HLT,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLR_RST: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SLOT_RD;
            end
         end
         ST_SLOT_RD: begin
            cmd.slot_rd = 1'b1;
            state_in    = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            case (status.req_type)
               bcbg_pkg::REQ_RECORD: state_in = ST_ARM;
               bcbg_pkg::REQ_HEALTHY: begin
                  if (status.mode == bcbg_pkg::MODE_HALF) begin
                     cmd.healthy_clr = 1'b1;
                     cmd.clr_start   = 1'b1;
                     state_in        = ST_CLR_HLT;
                  end else begin
                     state_in = ST_FIN;
                  end
               end
               default: state_in = ST_FIN;
            endcase
         end
         ST_ARM: begin
            cmd.arm  = 1'b1;
            state_in = ST_FIN;
            if (status.is_relaunch) begin
               if (status.mode == bcbg_pkg::MODE_CLOSED) begin
                  cmd.win_start = 1'b1;
                  state_in      = ST_WIN_RD;
               end else begin
                  cmd.half_set = 1'b1;
               end
            end
         end
         ST_WIN_RD: begin
            cmd.win_rd = 1'b1;
            state_in   = ST_WIN_CHK;
         end
         ST_WIN_CHK: begin
            cmd.win_chk = 1'b1;
            state_in    = status.win_last ? ST_WIN_INS : ST_WIN_RD;
         end
         ST_WIN_INS: begin
            cmd.win_ins = 1'b1;
            state_in    = ST_FIN;
         end
         ST_CLR_HLT: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end
endmodule

/* src/bcbg_dp.sv */
// Datapath for the backoff circuit breaker guard: item registers, slot table,
// relaunch window scan, breaker state and response register.
// Uses bcbg_pkg and bcbg_ram; driven by cmd_type from bcbg_ctrl.
module bcbg_dp #(
   parameter int SIG_SLOTS    = 64,
   parameter int WINDOW_DEPTH = 16,
   parameter int MAX_SHIFT    = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bcbg_pkg::cfg_type           cfg,
   input  bcbg_pkg::cmd_type           cmd,
   output bcbg_pkg::status_type        status,
   input  logic [1:0]                  in_req_type,
   input  logic [bcbg_pkg::SLOT_W-1:0] in_sig_slot,
   input  logic                        in_is_relaunch,
   input  logic [bcbg_pkg::NOW_W-1:0]  in_now_ms,
   output logic                        out_allowed,
   output logic [1:0]                  out_deny_reason,
   output logic [1:0]                  out_breaker_now
);
   localparam int NW   = bcbg_pkg::NOW_W;
   localparam int TW   = bcbg_pkg::TIME_W;
   localparam int CW   = bcbg_pkg::CFG_W;
   localparam int SAW  = (SIG_SLOTS > 1) ? $clog2(SIG_SLOTS) : 1;
   localparam int WAW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNTW = $clog2(WINDOW_DEPTH + 1);
   localparam int ATW  = $clog2(MAX_SHIFT + 1);
   localparam int SHW  = CW + MAX_SHIFT;
   localparam int SDW  = TW + ATW;

   // item
   logic [1:0]                  type_ff;
   logic [bcbg_pkg::SLOT_W-1:0] slot_ff;
   logic                        relaunch_ff;
   logic [NW-1:0]               now_ff;

   // breaker
   logic [1:0]    mode_ff;
   logic [TW-1:0] open_until_ff;
   logic [TW-1:0] cool_until;

   // slot table
   logic [31:0]    slot_ext;
   logic           slot_ok;
   logic [SAW-1:0] slot_addr;
   logic [SAW-1:0] clr_cnt_ff;
   logic           clr_last;
   logic           slot_we;
   logic [SAW-1:0] slot_waddr;
   logic [SDW-1:0] slot_wdata;
   logic [SDW-1:0] slot_rdata;
   logic [TW-1:0]  until_rd;
   logic [ATW-1:0] att_rd;
   logic [ATW-1:0] shift_amt;
   logic [SHW-1:0] shifted;
   logic [CW-1:0]  backoff_in, backoff_ff;
   logic [ATW-1:0] att_next_in, att_next_ff;
   logic [TW-1:0]  arm_until;

   // decision
   logic       allowed_in, allowed_ff;
   logic [1:0] reason_in, reason_ff;

   // window
   logic [WINDOW_DEPTH-1:0] wvalid_ff;
   logic [WAW-1:0]  wi_ff;
   logic            win_last;
   logic [CNTW-1:0] count_ff;
   logic            free_found_ff;
   logic [WAW-1:0]  free_idx_ff;
   logic            has_old_ff;
   logic [WAW-1:0]  old_idx_ff;
   logic [NW-1:0]   old_t_ff;
   logic [NW-1:0]   win_t;
   logic [NW-1:0]   win_diff;
   logic            win_v, win_stale, win_live;
   logic [WAW-1:0]  ins_addr;
   logic [CNTW-1:0] cnt_fin;
   logic            trip;

   // response
   logic       rsp_allowed_ff;
   logic [1:0] rsp_reason_ff;
   logic [1:0] rsp_breaker_ff;

   assign slot_ext   = 32'(slot_ff);
   assign slot_ok    = slot_ext < 32'(SIG_SLOTS);
   assign slot_addr  = slot_ext[SAW-1:0];
   assign clr_last   = (clr_cnt_ff == SAW'(SIG_SLOTS - 1));
   assign win_last   = (wi_ff == WAW'(WINDOW_DEPTH - 1));
   assign cool_until = TW'(now_ff) + TW'(cfg.cooldown_ms);

   assign until_rd = slot_rdata[SDW-1:ATW];
   assign att_rd   = slot_rdata[ATW-1:0];

   assign slot_we    = cmd.clr_step || (cmd.arm && slot_ok);
   assign slot_waddr = cmd.clr_step ? clr_cnt_ff : slot_addr;
   assign arm_until  = TW'(now_ff) + TW'(backoff_ff);
   assign slot_wdata = cmd.clr_step ? '0 : {arm_until, att_next_ff};

   bcbg_ram #(.WIDTH(SDW), .DEPTH(SIG_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (cmd.slot_rd),
      .rd_addr (slot_addr),
      .rd_data (slot_rdata)
   );

   // backoff and decision, from the slot entry just read
   always_comb begin
      shift_amt   = (att_rd > ATW'(MAX_SHIFT)) ? ATW'(MAX_SHIFT) : att_rd;
      shifted     = SHW'(cfg.base_ms) << shift_amt;
      backoff_in  = (shifted > SHW'(cfg.cap_ms)) ? cfg.cap_ms
                                                 : shifted[CW-1:0];
      att_next_in = (att_rd < ATW'(MAX_SHIFT)) ? att_rd + ATW'(1) : att_rd;

      allowed_in = 1'b0;
      reason_in  = bcbg_pkg::REASON_NONE;
      if (type_ff == bcbg_pkg::REQ_DECIDE) begin
         if (slot_ok && ({1'b0, now_ff} < until_rd)) begin
            reason_in = bcbg_pkg::REASON_BACKOFF;
         end else if (!relaunch_ff || mode_ff == bcbg_pkg::MODE_CLOSED) begin
            allowed_in = 1'b1;
         end else if ({1'b0, now_ff} >= open_until_ff) begin
            allowed_in = 1'b1;
         end else begin
            reason_in = (mode_ff == bcbg_pkg::MODE_OPEN) ? bcbg_pkg::REASON_OPEN
                                                         : bcbg_pkg::REASON_HALF;
         end
      end
   end

   // window scan, one entry per read/check pair
   bcbg_ram #(.WIDTH(NW), .DEPTH(WINDOW_DEPTH)) u_win_ram (
      .clock   (clock),
      .wr_en   (cmd.win_ins),
      .wr_addr (ins_addr),
      .wr_data (now_ff),
      .rd_en   (cmd.win_rd),
      .rd_addr (wi_ff),
      .rd_data (win_t)
   );

   assign win_v     = wvalid_ff[wi_ff];
   assign win_diff  = now_ff - win_t;
   assign win_stale = win_v && (win_t <= now_ff) && (win_diff > NW'(cfg.window_ms));
   assign win_live  = win_v && !win_stale;
   assign ins_addr  = free_found_ff ? free_idx_ff : old_idx_ff;
   assign cnt_fin   = count_ff + CNTW'(free_found_ff);
   assign trip      = 32'(cnt_fin) >= 32'(cfg.max_relaunches);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= bcbg_pkg::MODE_CLOSED;
         open_until_ff <= '0;
         wvalid_ff     <= '0;
         clr_cnt_ff    <= '0;
         wi_ff         <= '0;
      end else begin
         if (cmd.clr_start) begin
            clr_cnt_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_cnt_ff <= clr_last ? '0 : clr_cnt_ff + SAW'(1);
         end

         if (cmd.healthy_clr) begin
            mode_ff       <= bcbg_pkg::MODE_CLOSED;
            open_until_ff <= '0;
            wvalid_ff     <= '0;
         end else if (cmd.half_set) begin
            mode_ff       <= bcbg_pkg::MODE_HALF;
            open_until_ff <= cool_until;
         end else if (cmd.win_ins) begin
            wvalid_ff[ins_addr] <= 1'b1;
            if (trip) begin
               mode_ff       <= bcbg_pkg::MODE_OPEN;
               open_until_ff <= cool_until;
            end
         end else if (cmd.win_chk && win_stale) begin
            wvalid_ff[wi_ff] <= 1'b0;
         end

         if (cmd.win_start) begin
            wi_ff <= '0;
         end else if (cmd.win_chk) begin
            wi_ff <= win_last ? '0 : wi_ff + WAW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff     <= in_req_type;
         slot_ff     <= in_sig_slot;
         relaunch_ff <= in_is_relaunch;
         now_ff      <= in_now_ms;
      end
      if (cmd.calc) begin
         backoff_ff  <= backoff_in;
         att_next_ff <= att_next_in;
         allowed_ff  <= allowed_in;
         reason_ff   <= reason_in;
      end
      if (cmd.win_start) begin
         count_ff      <= '0;
         free_found_ff <= 1'b0;
         has_old_ff    <= 1'b0;
      end else if (cmd.win_chk) begin
         if (!win_live && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= wi_ff;
         end
         if (win_live) begin
            count_ff <= count_ff + CNTW'(1);
            if (!has_old_ff || win_t < old_t_ff) begin
               has_old_ff <= 1'b1;
               old_idx_ff <= wi_ff;
               old_t_ff   <= win_t;
            end
         end
      end
      if (cmd.rsp_load) begin
         rsp_allowed_ff <= allowed_ff;
         rsp_reason_ff  <= reason_ff;
         rsp_breaker_ff <= mode_ff;
      end
   end

   assign status.req_type    = type_ff;
   assign status.is_relaunch = relaunch_ff;
   assign status.mode        = mode_ff;
   assign status.clr_last    = clr_last;
   assign status.win_last    = win_last;

   assign out_allowed     = rsp_allowed_ff;
   assign out_deny_reason = rsp_reason_ff;
   assign out_breaker_now = rsp_breaker_ff;
endmodule

/* src/backoff_circuit_breaker_guard.sv */
// Backoff circuit breaker guard: gates recovery actions per signature slot
// with exponential backoff and a closed/open/half-open breaker.
// Channels: req_bus (req_type, sig_slot, is_relaunch, now_ms) in, rsp_bus
// (allowed, deny_reason, breaker_now) out, one response beat per request beat.
// csr_we/csr_index/csr_wdata write the five registers; write only when idle.
// Controller states per request, from accept to response valid:
//   decide, healthy without clearing, unused code: slot read, calc, finish
//   record without relaunch, or relaunch while open/half open: adds arm
//   relaunch while closed: adds arm, a window scan (read and check
//   of each entry through the window RAM port) and an insert
//   healthy while half open: adds the slot table clear (one entry
//   per cycle through its write port)
// The next request is taken the cycle after the response is registered.
// Reset: synchronous; the slot table is then cleared entry by entry,
// during which req_bus.ready stays low. Registers return to defaults.
// A stalled response holds in the output register; the block accepts the
// next request meanwhile and waits only when a second response is ready.
module backoff_circuit_breaker_guard #(
   parameter int SIG_SLOTS    = 64,
   parameter int WINDOW_DEPTH = 16,
   parameter int MAX_SHIFT    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   bcbg_req_if.sink                       req_bus,
   bcbg_rsp_if.source                     rsp_bus,
   input  logic                           csr_we,
   input  logic [bcbg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcbg_pkg::CFG_W-1:0]     csr_wdata
);
   bcbg_pkg::cfg_type    cfg;
   bcbg_pkg::cmd_type    cmd;
   bcbg_pkg::status_type status;

   bcbg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcbg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcbg_dp #(
      .SIG_SLOTS    (SIG_SLOTS),
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .MAX_SHIFT    (MAX_SHIFT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .in_req_type     (req_bus.req_type),
      .in_sig_slot     (req_bus.sig_slot),
      .in_is_relaunch  (req_bus.is_relaunch),
      .in_now_ms       (req_bus.now_ms),
      .out_allowed     (rsp_bus.allowed),
      .out_deny_reason (rsp_bus.deny_reason),
      .out_breaker_now (rsp_bus.breaker_now)
   );
endmodule
